// File: src/pla_pkg.sv
// Shared types and constants for the polyline length accumulator.
// Holds the controller state type, the command and status structs and the result widths.
// No dependencies.
package pla_pkg;

   localparam int SEG_W      = 17;
   localparam int TOTAL_W    = 32;
   localparam int RSP_DATA_W = 56;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic     load;       // capture the point, form the differences
      logic     mul_en;     // square the difference of the selected axis
      axis_type axis;
      logic     acc_en;     // add the registered square to the sum
      logic     root_step;  // one digit of the square root
      logic     finish;     // write the result register, update the total
   } cmd_type;

   typedef struct packed {
      logic have_prev;    // a previous point is stored
      logic out_free;     // the result register can take a new beat
   } status_type;

endpackage

// File: src/pla_ctrl.sv
// Controller of the polyline length accumulator: sequences load, squaring,
// square root iterations and result write. Depends on pla_pkg.
module pla_ctrl #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pla_pkg::status_type status,
   output pla_pkg::cmd_type    cmd
);

   localparam int ROOT_W = COORD_WIDTH + 1;
   localparam int CNT_W  = $clog2(ROOT_W);

   pla_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pla_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.axis      = pla_pkg::AXIS_X;
      req_tready    = 1'b0;
      unique case (state_ff)
         pla_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = status.have_prev ? pla_pkg::ST_SQUARE : pla_pkg::ST_FINISH;
            end
         end
         pla_pkg::ST_SQUARE: begin
            // Steps 0..2 square one axis each; steps 1..3 add the previous square.
            unique case (step_ff[1:0])
               2'd0: begin
                  cmd.mul_en = 1'b1;
                  cmd.axis   = pla_pkg::AXIS_X;
               end
               2'd1: begin
                  cmd.mul_en = 1'b1;
                  cmd.axis   = pla_pkg::AXIS_Y;
                  cmd.acc_en = 1'b1;
               end
               2'd2: begin
                  cmd.mul_en = 1'b1;
                  cmd.axis   = pla_pkg::AXIS_Z;
                  cmd.acc_en = 1'b1;
               end
               default: begin
                  cmd.acc_en = 1'b1;
               end
            endcase
            if (step_ff[1:0] == 2'd3) begin
               step_in  = CNT_W'(ROOT_W - 1);
               state_in = pla_pkg::ST_ROOT;
            end else begin
               step_in = step_ff + CNT_W'(1);
            end
         end
         pla_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == '0) begin
               state_in = pla_pkg::ST_FINISH;
            end else begin
               step_in = step_ff - CNT_W'(1);
            end
         end
         pla_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = pla_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pla_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/pla_datapath.sv
// Datapath of the polyline length accumulator: previous point, differences,
// shared squarer, bit-serial square root, running total and result register.
// Depends on pla_pkg; driven by pla_ctrl.
module pla_datapath #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pla_pkg::cmd_type                     cmd,
   output pla_pkg::status_type                  status,
   input  logic signed [COORD_WIDTH-1:0]        x_coord,
   input  logic signed [COORD_WIDTH-1:0]        y_coord,
   input  logic signed [COORD_WIDTH-1:0]        z_coord,
   input  logic                                 last_point,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [pla_pkg::SEG_W-1:0]            segment_length,
   output logic [pla_pkg::TOTAL_W-1:0]          total_length,
   output logic                                 total_saturated,
   output logic                                 path_done
);

   localparam int W      = COORD_WIDTH;
   localparam int SQ_W   = 2 * W;
   localparam int SUM_W  = 2 * W + 2;
   localparam int ROOT_W = W + 1;
   localparam int REM_W  = ROOT_W + 3;
   localparam int TADD_W = ((ROOT_W > pla_pkg::TOTAL_W) ? ROOT_W : pla_pkg::TOTAL_W) + 1;

   logic signed [W-1:0]         prev_x_ff, prev_y_ff, prev_z_ff;
   logic                        have_prev_ff;
   logic [pla_pkg::TOTAL_W-1:0] total_ff;
   logic                        sat_ff;
   logic                        has_seg_ff;
   logic                        last_ff;
   logic [W-1:0]                dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]             prod_ff;
   logic [SUM_W-1:0]            sum_ff;
   logic [REM_W-1:0]            rem_ff;
   logic [ROOT_W-1:0]           root_ff;
   logic                        rsp_valid_ff;
   logic [pla_pkg::SEG_W-1:0]   rsp_seg_ff;
   logic [pla_pkg::TOTAL_W-1:0] rsp_total_ff;
   logic                        rsp_sat_ff;
   logic                        rsp_last_ff;

   logic [W-1:0]                dx_in, dy_in, dz_in;
   logic [W-1:0]                mul_op;
   logic [REM_W-1:0]            rem_sh, trial;
   logic [ROOT_W-1:0]           seg;
   logic [TADD_W-1:0]           tsum;
   logic [pla_pkg::TOTAL_W-1:0] total_in;
   logic                        sat_in;

   function automatic logic [COORD_WIDTH-1:0] abs_diff(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      logic signed [COORD_WIDTH:0] d;
      d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      if (d[COORD_WIDTH]) begin
         d = -d;
      end
      return d[COORD_WIDTH-1:0];
   endfunction

   assign dx_in = abs_diff(x_coord, prev_x_ff);
   assign dy_in = abs_diff(y_coord, prev_y_ff);
   assign dz_in = abs_diff(z_coord, prev_z_ff);

   always_comb begin
      unique case (cmd.axis)
         pla_pkg::AXIS_X: mul_op = dx_ff;
         pla_pkg::AXIS_Y: mul_op = dy_ff;
         pla_pkg::AXIS_Z: mul_op = dz_ff;
         default:         mul_op = '0;
      endcase
   end

   // Restoring square root: bring down two radicand bits, try 4*root+1.
   assign rem_sh = {rem_ff[REM_W-3:0], sum_ff[SUM_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   assign seg  = has_seg_ff ? root_ff : '0;
   assign tsum = TADD_W'(total_ff) + TADD_W'(seg);

   always_comb begin
      total_in = total_ff;
      sat_in   = sat_ff;
      if (has_seg_ff) begin
         if (tsum >= TADD_W'(pla_pkg::TOTAL_MAX)) begin
            total_in = pla_pkg::TOTAL_MAX;
            sat_in   = 1'b1;
         end else begin
            total_in = tsum[pla_pkg::TOTAL_W-1:0];
         end
      end
   end

   // Trajectory state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         have_prev_ff <= 1'b0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            prev_x_ff    <= last_point ? '0 : x_coord;
            prev_y_ff    <= last_point ? '0 : y_coord;
            prev_z_ff    <= last_point ? '0 : z_coord;
            have_prev_ff <= !last_point;
         end
         if (cmd.finish) begin
            total_ff     <= last_ff ? '0 : total_in;
            sat_ff       <= last_ff ? 1'b0 : sat_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of one point.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         dz_ff      <= dz_in;
         has_seg_ff <= have_prev_ff;
         last_ff    <= last_point;
         sum_ff     <= '0;
         rem_ff     <= '0;
         root_ff    <= '0;
      end else begin
         if (cmd.mul_en) begin
            prod_ff <= mul_op * mul_op;
         end
         if (cmd.acc_en) begin
            sum_ff <= sum_ff + SUM_W'(prod_ff);
         end else if (cmd.root_step) begin
            sum_ff <= {sum_ff[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
      end
      if (cmd.finish) begin
         rsp_seg_ff   <= pla_pkg::SEG_W'(seg);
         rsp_total_ff <= total_in;
         rsp_sat_ff   <= sat_in;
         rsp_last_ff  <= last_ff;
      end
   end

   assign status.have_prev = have_prev_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid      = rsp_valid_ff;
   assign segment_length  = rsp_seg_ff;
   assign total_length    = rsp_total_ff;
   assign total_saturated = rsp_sat_ff;
   assign path_done       = rsp_last_ff;

endmodule

// File: src/polyline_length_accumulator_core.sv
// Each point passes three times through the shared squarer, then the square root takes
// one digit per cycle, then a finish state writes the result once the result register
// is free; the first point of a trajectory goes straight to the finish state. A new point
// is taken only once the previous one has finished.
// Reset is synchronous and active high; it clears the stored point, the total and the
// saturation flag and empties the result register.
module polyline_length_accumulator_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Point input stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: x_coord, y_coord, z_coord (COORD_WIDTH each), zero fill to bytes.
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tlast,   // last_point
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: segment_length (17), total_length (32), zero fill to 56 bits.
   output logic [pla_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,   // total_saturated
   output logic                              rsp_tlast    // path_done
);

   localparam int W = COORD_WIDTH;

   // Command and status buses between the sequencer and the datapath.
   pla_pkg::cmd_type    cmd;
   pla_pkg::status_type status;

   logic [pla_pkg::SEG_W-1:0]   segment_length;
   logic [pla_pkg::TOTAL_W-1:0] total_length;

   // The controller only takes a point while idle. A finished result sits in the
   // datapath's output register, so the next point can start while it waits.
   pla_ctrl #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath forms the absolute differences when the point is taken, squares
   // them one axis per cycle through one multiplier, extracts the floor square root
   // one bit per cycle and then adds the segment to the saturating total.
   pla_datapath #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .x_coord        (req_tdata[W-1:0]),
      .y_coord        (req_tdata[2*W-1:W]),
      .z_coord        (req_tdata[3*W-1:2*W]),
      .last_point     (req_tlast),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .segment_length (segment_length),
      .total_length   (total_length),
      .total_saturated(rsp_tuser),
      .path_done      (rsp_tlast)
   );

   // Result beat layout: segment length in the low bits, then the total.
   assign rsp_tdata = {
      (pla_pkg::RSP_DATA_W - pla_pkg::SEG_W - pla_pkg::TOTAL_W)'(0),
      total_length,
      segment_length
   };

endmodule

// File: src/pla_checker.sv
// Port-level checks for the polyline length accumulator, bound to its top level.
// Depends on pla_pkg and polyline_length_accumulator_core.
module pla_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [pla_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);

   localparam int TOT_LO = pla_pkg::SEG_W;
   localparam int TOT_HI = pla_pkg::SEG_W + pla_pkg::TOTAL_W - 1;

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A result beat is withdrawn only after it was taken.
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid) |-> $past(rsp_tready))
      else $error("result beat dropped without handshake");

   // One point at a time: the block is busy right after taking a point.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("point accepted while the previous one is in progress");

   // A saturated total is reported at its clamp value.
   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[TOT_HI:TOT_LO] == pla_pkg::TOTAL_MAX)
      else $error("saturation flag set on a total below its maximum");

endmodule

bind polyline_length_accumulator_core pla_checker u_pla_checker (.*);

// File: sim/tb_polyline_length_accumulator_core.sv
// Self-checking testbench for polyline_length_accumulator_core: streams 3D points in,
// predicts every segment length and running total, and checks each result beat in order.
// Depends on pla_pkg and the core RTL only.
module tb_polyline_length_accumulator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = 16;
   localparam int REQ_W = ((3 * COORD_W + 7) / 8) * 8;
   // Generous settle time after the last result.
   localparam int TAIL_CYCLES = 2 * (COORD_W + 7) + 10;
   // Length of the corner-to-corner path that runs with no idling on either side.
   localparam int FULL_RATE_POINTS = 60;
   localparam int RANDOM_POINTS = 420;
   localparam int IDLE_PERCENT = 6;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

   typedef struct packed {
      logic [pla_pkg::SEG_W-1:0]   seg;
      logic [pla_pkg::TOTAL_W-1:0] total;
      logic                        sat;
      logic                        done;
   } path_result_type;

   logic clock;
   logic reset = 1'b1;

   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // x_coord, y_coord, z_coord from bit 0
   logic             req_tlast  = 1'b0; // last_point

   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pla_pkg::RSP_DATA_W-1:0] rsp_tdata;  // segment_length, total_length from bit 0
   logic                           rsp_tuser;  // total_saturated
   logic                           rsp_tlast;  // path_done

   // Random idling on each side can be switched off for long full-rate stretches.
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   int errors = 0;

   // Expected result beats, oldest first, and the predictor's copy of the path state.
   path_result_type             pending_lengths[$];
   path_result_type             head_beat;
   coord_type                   last_x, last_y, last_z;
   logic                        have_point = 1'b0;
   logic [pla_pkg::TOTAL_W-1:0] path_total = '0;
   logic                        path_sat   = 1'b0;

   polyline_length_accumulator_core #(
      .COORD_WIDTH(COORD_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block stops answering; far above the slowest correct run.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Bit-serial floor square root, two bits of the radicand per step. The sum of squares
   // of 16-bit differences needs 34 bits, so 64 bits leave plenty of headroom.
   function automatic logic [pla_pkg::SEG_W-1:0] floor_sqrt(input logic [63:0] radicand);
      logic [63:0] rem;
      logic [63:0] root;
      rem  = '0;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         rem  = (rem << 2) | ((radicand >> (2 * i)) & 64'd3);
         root = root << 1;
         if (rem >= 2 * root + 1) begin
            rem  = rem - (2 * root + 1);
            root = root + 1;
         end
      end
      return root[pla_pkg::SEG_W-1:0];
   endfunction

   // Works out the result beat for one accepted point and advances the path state.
   // The first point of a path only gets stored; a last point clears everything after
   // its own result has been formed.
   task automatic predict_segment(input coord_type x, input coord_type y,
                                  input coord_type z, input logic last);
      longint                    dx, dy, dz;
      logic [63:0]               sum_sq;
      logic [pla_pkg::TOTAL_W:0] sum;
      path_result_type           beat;
      beat.seg = '0;
      if (have_point) begin
         dx = longint'(x) - longint'(last_x);
         dy = longint'(y) - longint'(last_y);
         dz = longint'(z) - longint'(last_z);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         if (dz < 0) dz = -dz;
         sum_sq   = dx * dx + dy * dy + dz * dz;
         beat.seg = floor_sqrt(sum_sq);
         sum      = {1'b0, path_total} + beat.seg;
         // Reaching the maximum exactly counts as saturation too.
         if (sum >= {1'b0, pla_pkg::TOTAL_MAX}) begin
            path_total = pla_pkg::TOTAL_MAX;
            path_sat   = 1'b1;
         end else begin
            path_total = sum[pla_pkg::TOTAL_W-1:0];
         end
      end
      last_x     = x;
      last_y     = y;
      last_z     = z;
      have_point = 1'b1;
      beat.total = path_total;
      beat.sat   = path_sat;
      beat.done  = last;
      pending_lengths.push_back(beat);
      if (last) begin
         last_x     = '0;
         last_y     = '0;
         last_z     = '0;
         have_point = 1'b0;
         path_total = '0;
         path_sat   = 1'b0;
      end
   endtask

   // Offers one point and waits for its beat to be taken. Valid is left high after the
   // accept so that back-to-back points never lower and raise it in the same step; the
   // next call either replaces the data or idles, and wait_drain drops it.
   task automatic send_point(input coord_type x, input coord_type y, input coord_type z,
                             input logic last);
      while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({z, y, x});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_segment(x, y, z, last);
   endtask

   // Stops offering points until every expected beat has come back, then lets the block
   // settle for a while.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Full-range values, small and medium steps from the previous point and some
   // extremes, so that segment lengths of every magnitude appear.
   function automatic coord_type rand_coord(input coord_type base);
      unique case ($urandom_range(3))
         0: return coord_type'($urandom);
         1: return base + coord_type'($urandom_range(64)) - coord_type'(32);
         2: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
         default: return base + coord_type'($urandom_range(4096)) - coord_type'(2048);
      endcase
   endfunction

   // One-point paths: length zero, total zero, not saturated, marked done.
   task automatic test_single_point();
      send_point(COORD_MAX, COORD_MIN, coord_type'(-1), 1'b1);
      send_point('0, '0, '0, 1'b1);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
   endtask

   // Full-scale diagonals, single-axis extremes, a zero-length step and sign changes.
   task automatic test_extreme_segments();
      send_point('0, '0, '0, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_point(coord_type'(1), '0, '0, 1'b0);
      send_point(coord_type'(-1), '0, '0, 1'b0);
      send_point(coord_type'(-1), coord_type'(-1), coord_type'(-1), 1'b0);
      send_point('0, coord_type'(1), coord_type'(1), 1'b1);
   endtask

   // The stored point and total must survive a long pause in the middle of a path.
   task automatic test_hold_off();
      send_point(coord_type'(100), coord_type'(-200), coord_type'(300), 1'b0);
      send_point(coord_type'(-5000), coord_type'(7000), coord_type'(12), 1'b0);
      send_point(coord_type'(3), coord_type'(4), '0, 1'b0);
      wait_drain();
      send_point(coord_type'(3), coord_type'(4), coord_type'(12), 1'b0);
      send_point(COORD_MIN, '0, COORD_MAX, 1'b0);
      send_point('0, '0, '0, 1'b1);
   endtask

   // A long path bouncing between opposite corners, run at full rate on both sides so
   // the total grows by the largest segment on every point. A fresh path follows.
   task automatic test_full_rate_corners();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      for (int i = 0; i <= FULL_RATE_POINTS; i++) begin
         if (i % 2 == 0) send_point(COORD_MIN, COORD_MIN, COORD_MIN, i == FULL_RATE_POINTS);
         else send_point(COORD_MAX, COORD_MAX, COORD_MAX, i == FULL_RATE_POINTS);
      end
      send_point('0, '0, '0, 1'b0);
      send_point(COORD_MAX, '0, '0, 1'b1);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // Random paths of random length, each closed by a last point.
   task automatic test_random_paths();
      int        sent;
      int        path_len;
      coord_type px, py, pz;
      sent = 0;
      px   = '0;
      py   = '0;
      pz   = '0;
      while (sent < RANDOM_POINTS) begin
         path_len = ($urandom_range(7) == 0) ? 1 : $urandom_range(20, 2);
         for (int k = 0; k < path_len; k++) begin
            px = rand_coord(px);
            py = rand_coord(py);
            pz = rand_coord(pz);
            send_point(px, py, pz, k == path_len - 1);
            sent++;
         end
      end
   endtask

   // Result side backpressure.
   always @(posedge clock) begin
      rsp_tready <= rx_idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
   end

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // Every result beat is matched against the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lengths.size() == 0) begin
            $display("%0t: result beat with nothing expected, segment %0d total %0d",
                     $time, rsp_tdata[pla_pkg::SEG_W-1:0],
                     rsp_tdata[pla_pkg::SEG_W+pla_pkg::TOTAL_W-1:pla_pkg::SEG_W]);
            errors++;
         end else begin
            head_beat = pending_lengths.pop_front();
            check_field("segment_length", head_beat.seg, rsp_tdata[pla_pkg::SEG_W-1:0]);
            check_field("total_length", head_beat.total,
                        rsp_tdata[pla_pkg::SEG_W+pla_pkg::TOTAL_W-1:pla_pkg::SEG_W]);
            check_field("total_saturated", head_beat.sat, rsp_tuser);
            check_field("path_done", head_beat.done, rsp_tlast);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_point();
      test_extreme_segments();
      test_hold_off();
      test_full_rate_corners();
      test_random_paths();

      wait_drain();
      if (pending_lengths.size() != 0) errors++;
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/pla_pkg.sv
src/pla_ctrl.sv
src/pla_datapath.sv
src/polyline_length_accumulator_core.sv
src/pla_checker.sv
sim/tb_polyline_length_accumulator_core.sv
